// ----- rtl/core/bfld_pkg.sv -----
// Package with the constants, types and item structs of the byte FIFO with line-end detection.
package bfld_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int FILL_W     = 7;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [0:0] {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              push_dropped;
    logic              is_empty;
    logic              is_full;
    logic [FILL_W-1:0] fill_count;
    logic              line_complete;
  } rsp_t;

  typedef struct packed {
    logic              pop_hit;
    logic              push_dropped;
    logic              is_empty;
    logic              is_full;
    logic [FILL_W-1:0] fill_count;
    logic              line_complete;
  } status_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ----- rtl/core/bfld_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bfld_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/bfld_ctrl.sv -----
// FIFO control: pointers, fill count, last two written bytes and per-item status.
module bfld_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bfld_pkg::cmd_t    item,
  output bfld_pkg::status_t status,
  output bfld_pkg::mem_req_t mem_req
);
  import bfld_pkg::*;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [7:0]       last_byte, last_byte_next;
  logic [7:0]       prev_byte, prev_byte_next;
  logic             is_push, push_ok, pop_ok, line_end;

  always_comb begin
    is_push = (item.kind == KIND_PUSH);
    push_ok = is_push && (held_count != FULL_CNT);
    pop_ok  = !is_push && (held_count != '0);

    held_count_next    = held_count;
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    last_byte_next     = last_byte;
    prev_byte_next     = prev_byte;

    if (push_ok) begin
      held_count_next    = held_count + CNT_W'(1);
      write_pointer_next = (write_pointer == LAST_IDX) ? '0 : write_pointer + PTR_W'(1);
      last_byte_next     = item.data_byte;
      prev_byte_next     = last_byte;
    end
    if (pop_ok) begin
      held_count_next   = held_count - CNT_W'(1);
      read_pointer_next = (read_pointer == LAST_IDX) ? '0 : read_pointer + PTR_W'(1);
    end

    line_end = (last_byte_next == CH_NUL)
            || ((last_byte_next == CH_CR) && (prev_byte_next == CH_LF))
            || ((last_byte_next == CH_LF) && (prev_byte_next == CH_CR));

    status.pop_hit       = pop_ok;
    status.push_dropped  = is_push && !push_ok;
    status.is_empty      = (held_count_next == '0);
    status.is_full       = (held_count_next == FULL_CNT);
    status.fill_count    = FILL_W'(held_count_next);
    status.line_complete = (held_count_next >= TWO_CNT) && line_end;

    mem_req.wr_en   = step && push_ok;
    mem_req.wr_addr = write_pointer;
    mem_req.wr_data = item.data_byte;
    mem_req.rd_en   = step && pop_ok;
    mem_req.rd_addr = read_pointer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      held_count    <= '0;
    end else if (step) begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      held_count    <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      last_byte <= last_byte_next;
      prev_byte <= prev_byte_next;
    end
  end

endmodule

// ----- rtl/core/byte_fifo_line_detect.sv -----
// Top level of the byte FIFO with line-end detection: input register, control, RAM, result register.
//
//   channel | direction | handshake           | payload
//   cmd     | in        | cmd_valid/cmd_stall | cmd (kind, data_byte)
//   rsp     | out       | rsp_valid/rsp_stall | rsp (read_byte, flags, fill_count, line_complete)
//
// One item per cycle sustained while rsp is not stalled; each item that is taken goes into the
// input register, then the result register and the RAM read are written before it shows on rsp.
// Reset clears pointers, fill count and both valid flags; RAM contents are not cleared.
// A stalled result holds both stages; cmd_stall rises only when the input register
// is full and cannot advance.
module byte_fifo_line_detect (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  bfld_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bfld_pkg::rsp_t rsp
);
  import bfld_pkg::*;

  logic     hold_valid;
  cmd_t     hold_item;
  logic     advance;
  logic     step;
  status_t  status;
  status_t  result;
  mem_req_t mem_req;
  logic [7:0] rd_data;

  assign advance   = !rsp_valid || !rsp_stall;
  assign step      = hold_valid && advance;
  assign cmd_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!cmd_stall) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      hold_item <= cmd;
    end
  end

  bfld_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (hold_item),
    .status  (status),
    .mem_req (mem_req)
  );

  bfld_ram #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= status;
    end
  end

  always_comb begin
    rsp.read_byte     = result.pop_hit ? rd_data : 8'h00;
    rsp.push_dropped  = result.push_dropped;
    rsp.is_empty      = result.is_empty;
    rsp.is_full       = result.is_full;
    rsp.fill_count    = result.fill_count;
    rsp.line_complete = result.line_complete;
  end

endmodule

// ----- sim/tb_byte_fifo_line_detect.sv -----
// Testbench for byte_fifo_line_detect: directed and random push/pop items checked against a predictor.
`timescale 1ns / 100ps

module tb_byte_fifo_line_detect;
  import bfld_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 320;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic [7:0] fifo_bytes [FIFO_DEPTH];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  int unsigned fill_level;

  rsp_t pending_rsp[$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned stall_len;
  bit gaps_on = 1'b0;
  bit stall_on = 1'b0;

  byte_fifo_line_detect i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int unsigned back_slot(int unsigned p, int unsigned n);
    return (p + FIFO_DEPTH - n) % FIFO_DEPTH;
  endfunction

  function automatic rsp_t fifo_step(cmd_t item);
    rsp_t res;
    logic [7:0] last_b;
    logic [7:0] prev_b;
    res = '0;
    if (item.kind == KIND_PUSH) begin
      if (fill_level < FIFO_DEPTH) begin
        fifo_bytes[PTR_W'(tail_ptr)] = item.data_byte;
        tail_ptr = (tail_ptr == FIFO_DEPTH - 1) ? 0 : tail_ptr + 1;
        fill_level++;
      end else begin
        res.push_dropped = 1'b1;
      end
    end else if (fill_level > 0) begin
      res.read_byte = fifo_bytes[PTR_W'(head_ptr)];
      head_ptr = (head_ptr == FIFO_DEPTH - 1) ? 0 : head_ptr + 1;
      fill_level--;
    end
    res.is_empty   = (fill_level == 0);
    res.is_full    = (fill_level == FIFO_DEPTH);
    res.fill_count = fill_level[FILL_W-1:0];
    if (fill_level >= 2) begin
      last_b = fifo_bytes[PTR_W'(back_slot(tail_ptr, 1))];
      prev_b = fifo_bytes[PTR_W'(back_slot(tail_ptr, 2))];
      res.line_complete = (last_b == CH_NUL) ||
                          (last_b == CH_CR && prev_b == CH_LF) ||
                          (last_b == CH_LF && prev_b == CH_CR);
    end
    return res;
  endfunction

  task automatic send_item(kind_t kind, logic [7:0] data_byte);
    int unsigned gap;
    cmd_t item;
    item.kind = kind;
    item.data_byte = data_byte;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    do @(posedge clk); while (cmd_stall);
    pending_rsp.push_back(fifo_step(item));
    items_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return CH_NUL;
      1:       return CH_CR;
      2:       return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_empty_pop();
    send_item(KIND_POP, 8'hFF);
    send_item(KIND_POP, 8'h00);
  endtask

  task automatic test_line_ends();
    send_item(KIND_PUSH, CH_NUL);
    send_item(KIND_PUSH, 8'h41);
    send_item(KIND_PUSH, CH_NUL);
    send_item(KIND_PUSH, CH_CR);
    send_item(KIND_PUSH, CH_LF);
    send_item(KIND_PUSH, CH_LF);
    send_item(KIND_PUSH, CH_CR);
    send_item(KIND_PUSH, CH_CR);
    send_item(KIND_PUSH, 8'hFF);
    send_item(KIND_PUSH, CH_NUL);
    repeat (11) send_item(KIND_POP, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_full_and_drain();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    repeat (FIFO_DEPTH + 2) send_item(KIND_PUSH, pick_byte());
    repeat (FIFO_DEPTH + 2) send_item(KIND_POP, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned phase_len;
    int unsigned push_pct;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 70);
      case ($urandom_range(0, 2))
        0:       push_pct = 88;
        1:       push_pct = 50;
        default: push_pct = 12;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct) send_item(KIND_PUSH, pick_byte());
        else send_item(KIND_POP, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || !stall_on) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_len = pick_gap();
      rsp_stall <= (stall_len != 0);
      stall_left <= (stall_len != 0) ? stall_len - 1 : 0;
    end
  end

  task automatic report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $time, rsp);
        error_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        report_field("read_byte", exp_rsp.read_byte, rsp.read_byte);
        report_field("push_dropped", 8'(exp_rsp.push_dropped), 8'(rsp.push_dropped));
        report_field("is_empty", 8'(exp_rsp.is_empty), 8'(rsp.is_empty));
        report_field("is_full", 8'(exp_rsp.is_full), 8'(rsp.is_full));
        report_field("fill_count", 8'(exp_rsp.fill_count), 8'(rsp.fill_count));
        report_field("line_complete", 8'(exp_rsp.line_complete), 8'(rsp.line_complete));
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    fifo_bytes = '{default: 8'h00};
    head_ptr = 0;
    tail_ptr = 0;
    fill_level = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_pop();
    test_line_ends();
    test_full_and_drain();
    test_random_traffic();

    cmd_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bfld_pkg.sv
rtl/core/bfld_ram.sv
rtl/core/bfld_ctrl.sv
rtl/core/byte_fifo_line_detect.sv
sim/tb_byte_fifo_line_detect.sv
